// ===== design/ray_sphere_hitbox_nearest_top_defines.svh =====
// Assertion macros shared by the hitbox ray test block.
// No dependencies; included by modules that carry concurrent checks.
`ifndef RAY_SPHERE_HITBOX_NEAREST_TOP_DEFINES_SVH
`define RAY_SPHERE_HITBOX_NEAREST_TOP_DEFINES_SVH

// Check that antecedent implies consequent in the same cycle, outside reset.
`define RSH_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check that antecedent implies consequent in the next cycle, outside reset.
`define RSH_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rsh_pkg.sv =====
// Shared types and constants for the hitbox ray test block.
// No dependencies.
package rsh_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_RADIUS_BOUND  = 3'd0;
    localparam logic [2:0] REG_CENTER_LIFT   = 3'd1;
    localparam logic [2:0] REG_RADIUS_HEAD   = 3'd2;
    localparam logic [2:0] REG_RADIUS_MID    = 3'd3;
    localparam logic [2:0] REG_RADIUS_SMALL  = 3'd4;
    localparam logic [2:0] REG_MISS_DISTANCE = 3'd5;

    localparam int SQRT_BITS = 36;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_TEST,
        ST_BQ,
        ST_BQCMP,
        ST_SQRT,
        ST_UPDATE,
        ST_OUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic       load;       // capture item operands
        logic       mul_clear;  // clear accumulators, reset product counter
        logic       mul_step;   // run one product
        logic       bq_step;    // square truncated |b|
        logic       sqrt_init;
        logic       sqrt_step;
        logic       restart;    // slot zero update
        logic       part_upd;   // part hit update
        logic       out_load;   // latch verdict into output
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic       mul_done;
        logic       origin_in;  // |m|^2 <= r^2
        logic       behind;     // pos > neg
        logic       bq_hit;
        logic       sqrt_done;
        logic       is_bound;
        logic       is_last;
        logic       bound_hit;  // stored bound flag
    } status_t;

endpackage

// ===== design/rsh_datapath.sv =====
// Datapath: operand capture, shared multiplier, accumulators, square root, state.
// Depends on rsh_pkg.
module rsh_datapath #(
    parameter int PART_COUNT = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  rsh_pkg::cmd_t      cmd,
    output rsh_pkg::status_t   sts,
    input  logic signed [31:0] origin_x, origin_y, origin_z,
    input  logic signed [31:0] dir_x, dir_y, dir_z,
    input  logic signed [31:0] center_x, center_y, center_z,
    input  logic [4:0]         sphere_slot,
    input  logic [30:0]        radius_bound, center_lift, radius_head,
    input  logic [30:0]        radius_mid, radius_small, miss_distance,
    output logic               hit_out,
    output logic signed [31:0] distance_out
);
    import rsh_pkg::*;

    // Operands
    logic signed [34:0] m_reg [3];
    logic signed [31:0] d_reg [3];
    logic [30:0]        r_reg;
    logic [4:0]         slot_reg;
    logic [1:0]         k_reg;     // product index, 0..3 (3 = r^2)
    logic               ph_reg;    // 0: m*m, 1: m*d

    // Accumulators
    logic [71:0] sum_reg, pos_reg, neg_reg, r2_reg, bq2_reg;
    logic [35:0] root_reg;
    logic [5:0]  sbit_reg;
    logic        bound_hit_reg, any_hit_reg;
    logic signed [31:0] least_reg;

    // Capture m = origin - centre, lift on the bound
    logic signed [34:0] my;
    logic [30:0]        rsel;
    always_comb begin
        my = 35'(origin_y) - 35'(center_y);
        if (sphere_slot == 5'd0) my = my - 35'(signed'({1'b0, center_lift}));
        if (sphere_slot == 5'd0)      rsel = radius_bound;
        else if (sphere_slot == 5'd1) rsel = radius_head;
        else if (sphere_slot <= 5'd5) rsel = radius_mid;
        else                          rsel = radius_small;
    end

    // One product per cycle through a shared 36x36 unsigned multiplier
    logic [35:0] mula, mulb;
    logic [71:0] prod;
    logic        neg_sign;
    logic [34:0] mmag;
    logic [31:0] dmag;
    always_comb begin
        mmag = 35'd0;
        dmag = 32'd0;
        neg_sign = 1'b0;
        mula = 36'd0;
        mulb = 36'd0;
        if (k_reg == 2'd3) begin
            mula = {5'd0, r_reg};
            mulb = {5'd0, r_reg};
        end else begin
            mmag = m_reg[k_reg][34] ? 35'(-m_reg[k_reg]) : 35'(m_reg[k_reg]);
            dmag = d_reg[k_reg][31] ? 32'(-d_reg[k_reg]) : 32'(d_reg[k_reg]);
            neg_sign = m_reg[k_reg][34] ^ d_reg[k_reg][31];
            mula = {1'b0, mmag};
            mulb = ph_reg ? {4'd0, dmag} : {1'b0, mmag};
        end
        prod = mula * mulb;
    end

    // Square root candidate and truncated |b|; a |b| of 2^35 or more already
    // clears any |m|^2, so clamp it there
    logic [71:0] bm;
    logic [35:0] cand;
    logic [71:0] cand_sq;
    logic [35:0] bmag;
    always_comb begin
        bm = neg_reg - pos_reg;
        bmag = (|bm[71:51]) ? 36'h8_0000_0000 : {1'b0, bm[50:16]};
        cand = root_reg | (36'd1 << sbit_reg);
        cand_sq = cand * cand;
    end

    // Distance: root - r, saturated
    logic signed [37:0] dist_full;
    logic signed [31:0] dist_sat;
    always_comb begin
        dist_full = 38'(signed'({2'b0, root_reg})) - 38'(signed'({7'd0, r_reg}));
        if (dist_full > 38'sd2147483647)       dist_sat = 32'h7fffffff;
        else if (dist_full < -38'sd2147483648) dist_sat = 32'h80000000;
        else                                   dist_sat = 32'(dist_full);
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_reg[0] <= 35'(origin_x) - 35'(center_x);
            m_reg[1] <= my;
            m_reg[2] <= 35'(origin_z) - 35'(center_z);
            d_reg[0] <= dir_x;
            d_reg[1] <= dir_y;
            d_reg[2] <= dir_z;
            r_reg    <= rsel;
            slot_reg <= sphere_slot;
        end
        if (cmd.mul_clear) begin
            sum_reg <= '0;
            pos_reg <= '0;
            neg_reg <= '0;
            k_reg   <= 2'd0;
            ph_reg  <= 1'b0;
        end else if (cmd.mul_step) begin
            if (k_reg == 2'd3) r2_reg <= prod;
            else if (!ph_reg) sum_reg <= sum_reg + prod;
            else if (neg_sign) neg_reg <= neg_reg + prod;
            else pos_reg <= pos_reg + prod;
            // advance: m*m then m*d per axis, then r^2
            if (k_reg != 2'd3 && !ph_reg) ph_reg <= 1'b1;
            else begin
                ph_reg <= 1'b0;
                k_reg  <= k_reg + 2'd1;
            end
        end
        if (cmd.bq_step) bq2_reg <= bmag * bmag;
        if (cmd.sqrt_init) begin
            root_reg <= '0;
            sbit_reg <= 6'(SQRT_BITS - 1);
        end else if (cmd.sqrt_step) begin
            if (cand_sq <= sum_reg) root_reg <= cand;
            sbit_reg <= sbit_reg - 6'd1;
        end
        if (cmd.out_load) begin
            hit_out      <= bound_hit_reg & any_hit_reg;
            distance_out <= (bound_hit_reg & any_hit_reg) ? least_reg : 32'sd0;
        end
    end

    // Test state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bound_hit_reg <= 1'b0;
            any_hit_reg   <= 1'b0;
            least_reg     <= 32'sd65536000;
        end else if (cmd.restart) begin
            bound_hit_reg <= sts.origin_in | (!sts.behind & sts.bq_hit);
            any_hit_reg   <= 1'b0;
            least_reg     <= signed'({1'b0, miss_distance});
        end else if (cmd.part_upd) begin
            any_hit_reg <= 1'b1;
            if (dist_sat < least_reg) least_reg <= dist_sat;
        end
    end

    always_comb begin
        sts.mul_done  = cmd.mul_step && k_reg == 2'd3;
        sts.origin_in = sum_reg <= r2_reg;
        sts.behind    = pos_reg > neg_reg;
        sts.bq_hit    = (bq2_reg + r2_reg) >= sum_reg;
        sts.sqrt_done = sbit_reg == 6'd0;
        sts.is_bound  = slot_reg == 5'd0;
        sts.is_last   = 7'(slot_reg) == 7'(PART_COUNT);
        sts.bound_hit = bound_hit_reg;
    end

endmodule

// ===== design/rsh_ctrl.sv =====
// Controller state machine sequencing one sphere test.
// Depends on rsh_pkg and the shared assertion macros.
`include "ray_sphere_hitbox_nearest_top_defines.svh"
module rsh_ctrl #(
    parameter int PART_COUNT = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [4:0]       sphere_slot,
    output logic             m_valid,
    input  logic             m_ready,
    output rsh_pkg::cmd_t    cmd,
    input  rsh_pkg::status_t sts
);
    import rsh_pkg::*;

    state_t state_reg, state_next;
    logic   mv_reg, mv_next;
    logic   accept, in_range;

    assign in_range = 7'(sphere_slot) <= 7'(PART_COUNT);
    assign accept   = s_valid & s_ready;
    // output register may still hold a result while idle
    assign s_ready  = state_reg == ST_IDLE;
    assign m_valid  = mv_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept && in_range) state_next = ST_MUL;
            ST_MUL:    if (sts.mul_done) state_next = ST_TEST;
            ST_TEST: begin
                if (!sts.is_bound && !sts.bound_hit) state_next = sts.is_last ? ST_OUT : ST_IDLE;
                else if (sts.origin_in) state_next = sts.is_bound ? ST_UPDATE : ST_SQRT;
                else if (sts.behind) state_next = sts.is_bound ? ST_UPDATE
                                                 : (sts.is_last ? ST_OUT : ST_IDLE);
                else state_next = ST_BQ;
            end
            ST_BQ:     state_next = ST_BQCMP;
            ST_BQCMP: begin
                if (sts.is_bound || sts.bq_hit) state_next = sts.is_bound ? ST_UPDATE : ST_SQRT;
                else state_next = sts.is_last ? ST_OUT : ST_IDLE;
            end
            ST_SQRT:   if (sts.sqrt_done) state_next = ST_UPDATE;
            ST_UPDATE: state_next = sts.is_last ? ST_OUT : ST_IDLE;
            ST_OUT:    if (!mv_reg || m_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd = '0;
        cmd.load = accept;
        unique case (state_reg)
            ST_IDLE:   cmd.mul_clear = 1'b1;
            ST_MUL:    cmd.mul_step  = 1'b1;
            ST_TEST:   cmd.sqrt_init = 1'b1;
            ST_BQ:     cmd.bq_step   = 1'b1;
            ST_BQCMP:  cmd.sqrt_init = 1'b1;
            ST_SQRT:   cmd.sqrt_step = 1'b1;
            ST_UPDATE: begin
                cmd.restart  = sts.is_bound;
                cmd.part_upd = !sts.is_bound;
            end
            ST_OUT:    cmd.out_load = !mv_reg || m_ready;
            default:   cmd = '0;
        endcase
    end

    // Result valid: set on load, drop on transfer
    always_comb begin
        mv_next = mv_reg;
        if (mv_reg && m_ready) mv_next = 1'b0;
        if (cmd.out_load) mv_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    `RSH_ASSERT_IMP(a_load_idle, aclk, aresetn, cmd.load, state_reg == ST_IDLE, "load outside idle")
    `RSH_ASSERT_NEXT(a_out_valid, aclk, aresetn, cmd.out_load, m_valid, "result not shown")
    `RSH_ASSERT_IMP(a_no_overwrite, aclk, aresetn, cmd.out_load && m_valid, m_ready, "result overwritten")
    `RSH_ASSERT_IMP(a_upd_excl, aclk, aresetn, cmd.restart, !cmd.part_upd, "restart and part update")

endmodule

// ===== design/ray_sphere_hitbox_nearest_top.sv =====
// Top level of the hitbox ray test: configuration registers, controller, datapath.
// Depends on rsh_pkg, rsh_ctrl and rsh_datapath.
//
// Tests a ray against one sphere per input transfer: slot 0 is the bounding sphere
// around the character, slots 1..PART_COUNT the part spheres; the last slot emits
// one result (hit, least distance minus radius). Each item runs through the shared
// multiplier (three |m|^2 terms, three m.d terms, r^2) and the test, then where needed
// the closest-approach square, the bit-serial square root on a part hit, and the
// update; on the last slot the result is then loaded. Slots above PART_COUNT are
// dropped. A new item is taken while the previous result waits in the output
// register.
module ray_sphere_hitbox_nearest_top #(
    parameter int PART_COUNT = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_origin_x, s_origin_y, s_origin_z,
    input  logic signed [31:0] s_dir_x, s_dir_y, s_dir_z,
    input  logic signed [31:0] s_center_x, s_center_y, s_center_z,
    input  logic [4:0]         s_sphere_slot,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_hit,
    output logic signed [31:0] m_distance
);
    import rsh_pkg::*;

    logic [30:0] radius_bound_reg, center_lift_reg, radius_head_reg;
    logic [30:0] radius_mid_reg, radius_small_reg, miss_distance_reg;
    cmd_t    cmd;
    status_t sts;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_bound_reg  <= 31'd393216;
            center_lift_reg   <= 31'd393216;
            radius_head_reg   <= 31'd131072;
            radius_mid_reg    <= 31'd98304;
            radius_small_reg  <= 31'd78643;
            miss_distance_reg <= 31'd65536000;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_RADIUS_BOUND:  radius_bound_reg  <= cfg_data;
                REG_CENTER_LIFT:   center_lift_reg   <= cfg_data;
                REG_RADIUS_HEAD:   radius_head_reg   <= cfg_data;
                REG_RADIUS_MID:    radius_mid_reg    <= cfg_data;
                REG_RADIUS_SMALL:  radius_small_reg  <= cfg_data;
                REG_MISS_DISTANCE: miss_distance_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    rsh_ctrl #(.PART_COUNT(PART_COUNT)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .sphere_slot(s_sphere_slot),
        .m_valid, .m_ready, .cmd, .sts
    );

    rsh_datapath #(.PART_COUNT(PART_COUNT)) u_dp (
        .aclk, .aresetn, .cmd, .sts,
        .origin_x(s_origin_x), .origin_y(s_origin_y), .origin_z(s_origin_z),
        .dir_x(s_dir_x), .dir_y(s_dir_y), .dir_z(s_dir_z),
        .center_x(s_center_x), .center_y(s_center_y), .center_z(s_center_z),
        .sphere_slot(s_sphere_slot),
        .radius_bound(radius_bound_reg), .center_lift(center_lift_reg),
        .radius_head(radius_head_reg), .radius_mid(radius_mid_reg),
        .radius_small(radius_small_reg), .miss_distance(miss_distance_reg),
        .hit_out(m_hit), .distance_out(m_distance)
    );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the hitbox ray test block ray_sphere_hitbox_nearest_top.
// Depends on rsh_pkg; a bit-exact predictor runs beside the block and checks each result.
`timescale 1ns / 1ps

module testbench;
    import rsh_pkg::*;

    localparam int PARTS = 16;
    localparam longint U = 65536;
    localparam int IDLE_LIMIT = 5000;
    localparam int ITEM_TARGET = 1850;
    localparam int PHASES = 10;

    typedef struct {
        logic signed [31:0] ox, oy, oz, dx, dy, dz, cx, cy, cz;
        logic [4:0] slot;
    } ray_item_t;

    typedef struct {
        logic hit;
        logic signed [31:0] dval;
    } verdict_t;

    typedef struct {
        ray_item_t it;
        bit typed;
        verdict_t v;
    } table_row_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [30:0] cfg_data;
    logic s_valid;
    logic s_ready;
    logic signed [31:0] s_origin_x, s_origin_y, s_origin_z;
    logic signed [31:0] s_dir_x, s_dir_y, s_dir_z;
    logic signed [31:0] s_center_x, s_center_y, s_center_z;
    logic [4:0] s_sphere_slot;
    logic m_valid;
    logic m_ready;
    logic m_hit;
    logic signed [31:0] m_distance;

    ray_sphere_hitbox_nearest_top #(.PART_COUNT(PARTS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_origin_x(s_origin_x), .s_origin_y(s_origin_y), .s_origin_z(s_origin_z),
        .s_dir_x(s_dir_x), .s_dir_y(s_dir_y), .s_dir_z(s_dir_z),
        .s_center_x(s_center_x), .s_center_y(s_center_y), .s_center_z(s_center_z),
        .s_sphere_slot(s_sphere_slot),
        .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit), .m_distance(m_distance)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Predictor state and register copies
    logic [30:0] reg_val [6];
    bit hb_bound_hit, hb_part_hit;
    logic signed [31:0] hb_least;

    verdict_t verdict_q[$];
    int fail_count = 0;
    int part_items = 0;
    int burst_left = 0;
    int hold_req = 0;

    function automatic logic [63:0] magn(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // Ray against one sphere; sum_sq returns |m|^2 in Q32.32
    function automatic bit sphere_hit(longint m[3], longint d[3], logic [63:0] r,
                                      output logic [127:0] sum_sq);
        logic [127:0] pos, neg, r2, bm, bq2, p;
        logic [63:0] bmag;
        pos = '0;
        neg = '0;
        sum_sq = '0;
        for (int k = 0; k < 3; k++) begin
            sum_sq += 128'(magn(m[k])) * 128'(magn(m[k]));
            p = 128'(magn(m[k])) * 128'(magn(d[k]));
            if ((m[k] < 0) != (d[k] < 0)) neg += p;
            else pos += p;
        end
        r2 = 128'(r) * 128'(r);
        if (sum_sq <= r2) return 1'b1;
        if (pos > neg) return 1'b0;
        bm = neg - pos;
        bmag = bm[79:16];
        bq2 = 128'(bmag) * 128'(bmag);
        return (bq2 + r2) >= sum_sq;
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [127:0] n);
        logic [63:0] res, cand;
        res = '0;
        for (int b = 35; b >= 0; b--) begin
            cand = res | (64'd1 << b);
            if (128'(cand) * 128'(cand) <= n) res = cand;
        end
        return res;
    endfunction

    // Advance the predictor by one accepted item; returns 1 when a verdict is due
    function automatic bit hitbox_predict(ray_item_t it, output verdict_t v);
        longint m[3], d[3], dnear;
        logic [127:0] sq;
        logic [63:0] r;
        int part;
        v.hit = 1'b0;
        v.dval = '0;
        if (it.slot > PARTS) return 1'b0;
        m[0] = longint'(it.ox) - longint'(it.cx);
        m[1] = longint'(it.oy) - longint'(it.cy);
        m[2] = longint'(it.oz) - longint'(it.cz);
        d[0] = it.dx;
        d[1] = it.dy;
        d[2] = it.dz;
        if (it.slot == 0) begin
            m[1] -= longint'(reg_val[REG_CENTER_LIFT]);
            hb_bound_hit = sphere_hit(m, d, 64'(reg_val[REG_RADIUS_BOUND]), sq);
            hb_part_hit = 1'b0;
            hb_least = 32'(reg_val[REG_MISS_DISTANCE]);
        end else if (hb_bound_hit) begin
            part = it.slot - 1;
            r = part == 0 ? 64'(reg_val[REG_RADIUS_HEAD]) :
                part <= 4 ? 64'(reg_val[REG_RADIUS_MID]) : 64'(reg_val[REG_RADIUS_SMALL]);
            if (sphere_hit(m, d, r, sq)) begin
                dnear = longint'(floor_sqrt(sq)) - longint'(r);
                if (dnear > 64'sd2147483647) dnear = 64'sd2147483647;
                if (dnear < -64'sd2147483648) dnear = -64'sd2147483648;
                if (dnear < longint'(hb_least)) hb_least = 32'(dnear);
                hb_part_hit = 1'b1;
            end
        end
        if (it.slot == PARTS) begin
            v.hit = hb_bound_hit && hb_part_hit;
            v.dval = v.hit ? hb_least : 32'sd0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Offer one item and hold it until the transfer, then pace the next by burst
    task automatic send_item(ray_item_t it, bit typed = 0, verdict_t tv = '{0, 0});
        verdict_t v;
        int gap;
        s_valid <= 1'b1;
        s_origin_x <= it.ox; s_origin_y <= it.oy; s_origin_z <= it.oz;
        s_dir_x <= it.dx; s_dir_y <= it.dy; s_dir_z <= it.dz;
        s_center_x <= it.cx; s_center_y <= it.cy; s_center_z <= it.cz;
        s_sphere_slot <= it.slot;
        do @(posedge aclk); while (!s_ready);
        if (hitbox_predict(it, v)) verdict_q.push_back(typed ? tv : v);
        if (it.slot <= PARTS) part_items++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 15);
            burst_left = $urandom_range(0, 40);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Hold until every verdict has come and the block has gone quiet
    task automatic drain();
        if (s_valid) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_regs(logic [30:0] vals [6]);
        for (int i = 0; i < 6; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data <= vals[i];
            @(posedge aclk);
            reg_val[i] = vals[i];
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic ray_item_t mk(longint ox, longint oy, longint oz, longint dx,
                                     longint dy, longint dz, longint cx, longint cy,
                                     longint cz, int slot);
        ray_item_t it;
        it.ox = 32'(ox); it.oy = 32'(oy); it.oz = 32'(oz);
        it.dx = 32'(dx); it.dy = 32'(dy); it.dz = 32'(dz);
        it.cx = 32'(cx); it.cy = 32'(cy); it.cz = 32'(cz);
        it.slot = 5'(slot);
        return it;
    endfunction

    function automatic ray_item_t noise_item();
        return mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom_range(0, 31));
    endfunction

    function automatic real jitter(real span);
        return ($urandom_range(0, 20000) / 10000.0 - 1.0) * span;
    endfunction

    // One shot at a character: bound, then parts, mostly aimed near the body
    task automatic send_shot(bit broken);
        real px, py, pz, ox, oy, oz, tx, ty, tz, len;
        longint dx, dy, dz;
        ray_item_t it;
        px = jitter(50.0); py = jitter(10.0); pz = jitter(50.0);
        ox = px + jitter(40.0); oy = py + jitter(10.0); oz = pz + jitter(40.0);
        tx = px + jitter(3.0); ty = py + 6.0 + jitter(5.0); tz = pz + jitter(3.0);
        len = $sqrt((tx - ox) ** 2 + (ty - oy) ** 2 + (tz - oz) ** 2);
        if (len < 0.01 || $urandom_range(0, 9) == 0) begin
            dx = U; dy = 0; dz = 0;
        end else begin
            dx = $rtoi((tx - ox) / len * U);
            dy = $rtoi((ty - oy) / len * U);
            dz = $rtoi((tz - oz) / len * U);
        end
        for (int s = 0; s <= PARTS; s++) begin
            if (broken && s < PARTS && $urandom_range(0, 5) == 0) continue;
            it = mk($rtoi(ox * U), $rtoi(oy * U), $rtoi(oz * U), dx, dy, dz,
                    $rtoi((px + jitter(2.0)) * U), $rtoi((py + 6.0 + jitter(4.0)) * U),
                    $rtoi((pz + jitter(2.0)) * U), s);
            if (s == 0) begin
                it.cx = $rtoi(px * U); it.cy = $rtoi(py * U); it.cz = $rtoi(pz * U);
            end
            if (broken && $urandom_range(0, 7) == 0) it = noise_item();
            send_item(it);
        end
    endtask

    function automatic logic [30:0] rand_reg(int idx);
        if ($urandom_range(0, 9) == 0) return 31'($urandom);
        if (idx == REG_MISS_DISTANCE) return 31'($urandom_range(0, 2000 * U));
        if (idx == REG_CENTER_LIFT) return 31'($urandom_range(0, 10 * U));
        return 31'($urandom_range(0, 8 * U));
    endfunction

    // Receiver: stall pattern changes in stretches; long hold-off on request
    int rx_mode = 0;
    int rx_count = 0;
    int rx_hold = 0;
    always @(posedge aclk) begin
        rx_count <= rx_count + 1;
        if (rx_count % 97 == 0) rx_mode <= $urandom_range(0, 2);
        if (hold_req > 0 && rx_hold == 0) begin
            rx_hold <= hold_req;
            m_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Compare each transfer on the result channel with the oldest verdict
    int idle_cycles = 0;
    always @(posedge aclk) begin
        verdict_t v;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $error("unexpected result hit=%0d distance=%0d", m_hit, m_distance);
                fail_count++;
            end else begin
                v = verdict_q.pop_front();
                if (m_hit !== v.hit) begin
                    $error("hit: expected %0d, actual %0d", v.hit, m_hit);
                    fail_count++;
                end
                if (m_distance !== v.dval) begin
                    $error("distance: expected %0d, actual %0d", v.dval, m_distance);
                    fail_count++;
                end
            end
        end
        // Watchdog: count cycles with no transfer anywhere
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        table_row_t rows[$];
        logic [30:0] vals [6];
        localparam longint MX = 64'sd2147483647;
        localparam longint MN = -64'sd2147483648;
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_origin_x <= '0; s_origin_y <= '0; s_origin_z <= '0;
        s_dir_x <= '0; s_dir_y <= '0; s_dir_z <= '0;
        s_center_x <= '0; s_center_y <= '0; s_center_z <= '0;
        s_sphere_slot <= '0;
        m_ready <= 1'b0;
        reg_val = '{393216, 393216, 131072, 98304, 78643, 65536000};
        hb_bound_hit = 0;
        hb_part_hit = 0;
        hb_least = 65536000;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: typed verdicts where they are obvious
        rows.push_back('{mk(0, 0, 0, U, 0, 0, 0, 0, 0, PARTS), 1, '{0, 0}});
        rows.push_back('{mk(MX, MX, MX, MX, MX, MX, MX, MX, MX, 17), 0, '{0, 0}});
        rows.push_back('{mk(MN, MN, MN, MN, MN, MN, MN, MN, MN, 31), 0, '{0, 0}});
        // origin inside the bound and the head; last part behind the ray
        rows.push_back('{mk(0, 6 * U, 0, -U, 0, 0, 0, 0, 0, 0), 0, '{0, 0}});
        rows.push_back('{mk(0, 6 * U, 0, -U, 0, 0, 0, 6 * U, 0, 1), 0, '{0, 0}});
        rows.push_back('{mk(0, 6 * U, 0, -U, 0, 0, 1000 * U, 0, 0, PARTS), 1,
                         '{1, -131072}});
        // bound missed: parts change nothing
        rows.push_back('{mk(0, 100 * U, 0, 0, U, 0, 0, 0, 0, 0), 0, '{0, 0}});
        rows.push_back('{mk(0, 100 * U, 0, 0, U, 0, 0, 100 * U, 0, 1), 0, '{0, 0}});
        rows.push_back('{mk(0, 100 * U, 0, 0, U, 0, 0, 100 * U, 0, PARTS), 1, '{0, 0}});
        // closest-approach hits from outside
        rows.push_back('{mk(0, 6 * U, -20 * U, 0, 0, U, 0, 0, 0, 0), 0, '{0, 0}});
        rows.push_back('{mk(0, 6 * U, -20 * U, 0, 0, U, 0, 6 * U, 0, 3), 0, '{0, 0}});
        rows.push_back('{mk(0, 6 * U, -20 * U, 0, 0, U, U / 2, 6 * U, 10 * U, 8), 0,
                         '{0, 0}});
        rows.push_back('{mk(0, 6 * U, -20 * U, 0, 0, U, 0, 6 * U, 5 * U, 2), 0, '{0, 0}});
        rows.push_back('{mk(0, 6 * U, -20 * U, 0, 0, U, 0, 7 * U, 9 * U, PARTS), 0,
                         '{0, 0}});
        // field extremes
        rows.push_back('{mk(MX, MX, MX, MN, MN, MN, MN, MN, MN, 0), 0, '{0, 0}});
        rows.push_back('{mk(MN, MN, MN, MX, MX, MX, MX, MX, MX, 5), 0, '{0, 0}});
        rows.push_back('{mk(MX, MN, MX, MN, MX, MN, MN, MX, MN, PARTS), 0, '{0, 0}});
        rows.push_back('{mk(MX, MX, MX, MX, MX, MX, MX, MX, MX, 0), 0, '{0, 0}});
        rows.push_back('{mk(MX, MX, MX, MX, MX, MX, MX, MX, MX, PARTS), 0, '{0, 0}});
        foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].v);
        drain();

        // Random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++) begin
            for (int i = 0; i < 6; i++) begin
                case (p)
                    0: vals[i] = reg_val[i];
                    1: vals[i] = '0;
                    2: vals[i] = '1;
                    default: vals[i] = rand_reg(i);
                endcase
            end
            if (p == 0) vals = '{393216, 393216, 131072, 98304, 78643, 65536000};
            write_regs(vals);
            while (part_items < ITEM_TARGET * (p + 1) / PHASES) begin
                if (p == 4 && hold_req == 0 && part_items % 50 < 17) hold_req = 600;
                if (p == 4 && rx_hold > 0) hold_req = 0;
                case ($urandom_range(0, 9))
                    0: send_item(noise_item());
                    1, 2: send_shot(1'b1);
                    default: send_shot(1'b0);
                endcase
            end
            hold_req = 0;
            drain();
        end

        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== ray_sphere_hitbox_nearest_top.f =====
+incdir+design
design/rsh_pkg.sv
design/rsh_datapath.sv
design/rsh_ctrl.sv
design/ray_sphere_hitbox_nearest_top.sv
tb/testbench.sv
